// ===== hdl/brf_pkg.sv =====
// Package for the chunked byte ring FIFO: request kinds, control states and
// the packed request and response item types. No dependencies.
`timescale 1ns / 1ps

package brf_pkg;

	localparam int BYTE_W  = 8;
	localparam int LANES   = 8;
	localparam int CNT_W   = 4;
	localparam int LEVEL_W = 11;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_BREAK = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_RDW,
		ST_DONE
	} state_t;

	typedef struct packed {
		req_kind_t                  req_type;
		logic [LANES*BYTE_W-1:0]    wdata;
		logic [CNT_W-1:0]           byte_count;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0]           moved_count;
		logic [LANES*BYTE_W-1:0]    rdata;
		logic [LEVEL_W-1:0]         fill_level;
		logic [LEVEL_W-1:0]         free_space;
		logic                       broken;
	} rsp_t;

endpackage

// ===== hdl/brf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/byte_ring_fifo_chunked_top.sv =====
// Chunked byte ring FIFO: top level with control sequencer and counters.
// Depends on brf_pkg and brf_ram.
//
// Usage: one request item enters on req (valid/ready) and exactly one response
// item leaves on rsp (valid/ready). A request writes up to eight bytes, reads up
// to eight bytes, clears both ring counters, or sets the sticky break flag.
// Writes store as many bytes as fit and none after a break; reads return as many
// bytes as are stored, first byte in the lowest lane.
// Bytes move one per cycle through a single byte-wide RAM, so the sequencer
// handles one item at a time and req_ready is high only when it is idle.
// A write of n bytes steps through ST_WR and ST_DONE, a read of n bytes through
// ST_RD, ST_RDW and ST_DONE, and clear, break or a request that moves nothing
// goes straight to ST_DONE, where the response register and rsp_valid are loaded.
// The next item may be accepted in the cycle after the response is loaded.
// The response sits in an output register; while the receiver stalls, the block
// still accepts one more item, finishes it and holds its response with req_ready
// low until rsp_ready.
// Reset clears the counters, the break flag and all handshakes; the RAM content
// is not cleared, and only written entries are ever read.
`timescale 1ns / 1ps

module byte_ring_fifo_chunked_top #(
	parameter int RING_BYTES  = 1024,
	parameter int CHUNK_BYTES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  brf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output brf_pkg::rsp_t rsp
);

	localparam int AW   = $clog2(RING_BYTES);
	localparam int RING = 1 << AW;
	localparam int CW   = AW + 1;
	localparam int XW   = (CW > brf_pkg::CNT_W) ? CW : brf_pkg::CNT_W;

	brf_pkg::state_t state_q, state_d;

	logic [CW-1:0]  wc_q, rc_q;
	logic           broken_q;
	logic [2:0]     idx_q;
	logic [brf_pkg::CNT_W-1:0] moved_q;
	logic [brf_pkg::LANES*brf_pkg::BYTE_W-1:0] wdata_q, rdata_q;
	logic           rd_pend_s1;
	logic [2:0]     rd_lane_s1;
	logic           rsp_valid_q;
	brf_pkg::rsp_t  rsp_q;

	logic                      accept;
	logic [brf_pkg::CNT_W-1:0] sat_cnt, wr_moved, rd_moved, acc_moved;
	logic [CW-1:0]             fill_now, room_now;
	logic [XW-1:0]             x_req, x_fill, x_room;
	logic                      last;
	logic                      ram_we, ram_re, load_rsp;
	logic [AW-1:0]             waddr, raddr;
	logic [brf_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
	logic [31:0]               fill_ext, room_ext;

	assign accept   = req_valid && req_ready;
	assign sat_cnt  = (req.byte_count > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : req.byte_count;
	assign fill_now = wc_q - rc_q;
	assign room_now = CW'(RING) - fill_now;
	assign x_req    = XW'(sat_cnt);
	assign x_fill   = XW'(fill_now);
	assign x_room   = XW'(room_now);
	assign wr_moved = broken_q ? '0 : ((x_req < x_room) ? sat_cnt : 4'(x_room));
	assign rd_moved = (x_req < x_fill) ? sat_cnt : 4'(x_fill);
	assign last     = (idx_q == 3'(moved_q - 4'd1));

	always_comb begin
		case (req.req_type)
			brf_pkg::REQ_WRITE: acc_moved = wr_moved;
			brf_pkg::REQ_READ:  acc_moved = rd_moved;
			default:            acc_moved = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			brf_pkg::ST_IDLE: begin
				if (accept) begin
					if ((req.req_type == brf_pkg::REQ_WRITE) && (wr_moved != '0)) begin
						state_d = brf_pkg::ST_WR;
					end else if ((req.req_type == brf_pkg::REQ_READ) && (rd_moved != '0)) begin
						state_d = brf_pkg::ST_RD;
					end else begin
						state_d = brf_pkg::ST_DONE;
					end
				end
			end
			brf_pkg::ST_WR: begin
				if (last) begin
					state_d = brf_pkg::ST_DONE;
				end
			end
			brf_pkg::ST_RD: begin
				if (last) begin
					state_d = brf_pkg::ST_RDW;
				end
			end
			brf_pkg::ST_RDW: state_d = brf_pkg::ST_DONE;
			brf_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = brf_pkg::ST_IDLE;
				end
			end
			default: state_d = brf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			brf_pkg::ST_IDLE: req_ready = 1'b1;
			brf_pkg::ST_WR:   ram_we = 1'b1;
			brf_pkg::ST_RD:   ram_re = 1'b1;
			brf_pkg::ST_DONE: load_rsp = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	assign waddr     = wc_q[AW-1:0] + AW'(idx_q);
	assign raddr     = rc_q[AW-1:0] + AW'(idx_q);
	assign ram_wdata = wdata_q[idx_q*brf_pkg::BYTE_W +: brf_pkg::BYTE_W];

	brf_ram #(
		.WIDTH(brf_pkg::BYTE_W),
		.DEPTH(RING)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brf_pkg::ST_IDLE;
			wc_q        <= '0;
			rc_q        <= '0;
			broken_q    <= 1'b0;
			idx_q       <= '0;
			rd_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= ram_re;
			if (accept) begin
				idx_q <= '0;
				case (req.req_type)
					brf_pkg::REQ_CLEAR: begin
						wc_q <= '0;
						rc_q <= '0;
					end
					brf_pkg::REQ_BREAK: broken_q <= 1'b1;
					default: ;
				endcase
			end
			if (ram_we || ram_re) begin
				idx_q <= idx_q + 3'd1;
			end
			if (ram_we && last) begin
				wc_q <= wc_q + CW'(moved_q);
			end
			if (ram_re && last) begin
				rc_q <= rc_q + CW'(moved_q);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign fill_ext = 32'(fill_now);
	assign room_ext = 32'(room_now);

	always_ff @(posedge clk) begin
		rd_lane_s1 <= idx_q;
		if (accept) begin
			moved_q <= acc_moved;
			wdata_q <= req.wdata;
			rdata_q <= '0;
		end
		if (rd_pend_s1) begin
			rdata_q[rd_lane_s1*brf_pkg::BYTE_W +: brf_pkg::BYTE_W] <= ram_rdata;
		end
		if (load_rsp) begin
			rsp_q.moved_count <= moved_q;
			rsp_q.rdata       <= rdata_q;
			rsp_q.fill_level  <= fill_ext[brf_pkg::LEVEL_W-1:0];
			rsp_q.free_space  <= room_ext[brf_pkg::LEVEL_W-1:0];
			rsp_q.broken      <= broken_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_moved_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.moved_count <= 4'(CHUNK_BYTES)))
		else $error("response moved more bytes than a chunk");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(x_fill <= XW'(RING)))
		else $error("ring fill exceeds ring size");

	a_rd_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == brf_pkg::ST_RD || state_q == brf_pkg::ST_RDW))
		else $error("read data returned outside a read sequence");

	a_break_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		broken_q |=> broken_q)
		else $error("break flag cleared without reset");

endmodule
